// ----- design/mlpd_pkg.sv -----
// Package for the magic-length packet deframer.
// Holds header constants, status codes, the magic byte table and the result type.
// No dependencies.
`default_nettype none

package mlpd_pkg;

    localparam int MAX_PACKETS = 16;
    localparam int CNT_W       = $clog2(MAX_PACKETS + 1);

    localparam logic [2:0] HP_MAGIC_LAST = 3'd2;
    localparam logic [2:0] HP_LEN_HI     = 3'd3;
    localparam logic [2:0] HP_LEN_LO     = 3'd4;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_OK       = 3'd1,
        ST_SYNC     = 3'd2,
        ST_TOOMANY  = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_DISCARD  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        is_payload;
        logic [3:0]  packet_index;
        logic [15:0] packet_length;
        logic        packet_end;
        t_status     status;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h4F;
            2'd1:    b = 8'h43;
            2'd2:    b = 8'h43;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/mlpd_parse.sv -----
// Input register and header/payload parser of the packet deframer.
// Computes one result per request from the parse state; uses mlpd_pkg.
`default_nettype none

module mlpd_parse (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [7:0]            i_byte_in,
    input  wire                   i_first_byte,
    input  wire                   i_last_byte,
    input  wire                   i_out_ready,
    output logic                  o_res_valid,
    output mlpd_pkg::t_result     o_res
);

    logic                       r_in_valid;
    logic [7:0]                 r_byte;
    logic                       r_first;
    logic                       r_last;

    logic [2:0]                 r_hp, n_hp;
    logic                       r_in_payload, n_in_payload;
    logic [15:0]                r_len, n_len;
    logic [15:0]                r_rem, n_rem;
    logic [mlpd_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_stopped, n_stopped;

    logic                       in_load;
    logic                       advance;
    logic [2:0]                 e_hp;
    logic                       e_in_payload;
    logic [15:0]                e_len;
    logic [15:0]                e_rem;
    logic [mlpd_pkg::CNT_W-1:0] e_count;
    logic                       e_stopped;
    logic [15:0]                rem_dec;
    logic [15:0]                len_full;
    logic [8:0]                 count_ext;
    logic                       count_below_max;
    mlpd_pkg::t_result          res;

    assign in_load     = !r_in_valid || i_out_ready;
    assign o_stall     = !in_load;
    assign advance     = r_in_valid && i_out_ready;
    assign o_res_valid = r_in_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_byte  <= i_byte_in;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp         <= '0;
            r_in_payload <= 1'b0;
            r_len        <= '0;
            r_rem        <= '0;
            r_count      <= '0;
            r_stopped    <= 1'b1;
        end else if (advance) begin
            r_hp         <= n_hp;
            r_in_payload <= n_in_payload;
            r_len        <= n_len;
            r_rem        <= n_rem;
            r_count      <= n_count;
            r_stopped    <= n_stopped;
        end
    end

    always_comb begin
        e_hp         = r_first ? 3'd0 : r_hp;
        e_in_payload = r_first ? 1'b0 : r_in_payload;
        e_len        = r_first ? 16'd0 : r_len;
        e_rem        = r_first ? 16'd0 : r_rem;
        e_count      = r_first ? '0 : r_count;
        e_stopped    = r_first ? 1'b0 : r_stopped;

        rem_dec         = e_rem - 16'd1;
        len_full        = {e_len[15:8], r_byte};
        count_ext       = 9'(e_count);
        count_below_max = (e_count < mlpd_pkg::CNT_W'(mlpd_pkg::MAX_PACKETS));

        n_hp         = e_hp;
        n_in_payload = e_in_payload;
        n_len        = e_len;
        n_rem        = e_rem;
        n_count      = e_count;
        n_stopped    = e_stopped;

        res.byte_out      = r_byte;
        res.is_payload    = 1'b0;
        res.packet_index  = count_ext[3:0];
        res.packet_length = '0;
        res.packet_end    = 1'b0;
        res.status        = mlpd_pkg::ST_PROGRESS;

        if (e_stopped) begin
            res.status       = mlpd_pkg::ST_DISCARD;
            res.packet_index = '0;
        end else if (e_in_payload) begin
            res.is_payload    = 1'b1;
            res.packet_length = e_len;
            n_rem             = rem_dec;
            if (rem_dec == 16'd0) begin
                res.packet_end = 1'b1;
                n_in_payload   = 1'b0;
                n_hp           = 3'd0;
                if (count_below_max) begin
                    n_count = e_count + mlpd_pkg::CNT_W'(1);
                end
                if (r_last) begin
                    res.status = mlpd_pkg::ST_OK;
                    n_stopped  = 1'b1;
                end
            end else if (r_last) begin
                res.status = mlpd_pkg::ST_TRUNC;
                n_stopped  = 1'b1;
            end
        end else if (e_hp <= mlpd_pkg::HP_MAGIC_LAST) begin
            if (r_byte != mlpd_pkg::magic_byte(e_hp[1:0]) || r_last) begin
                res.status = mlpd_pkg::ST_SYNC;
                n_stopped  = 1'b1;
            end else begin
                n_hp = e_hp + 3'd1;
            end
        end else if (e_hp == mlpd_pkg::HP_LEN_HI) begin
            n_len = {r_byte, 8'h00};
            if (r_last) begin
                res.status = mlpd_pkg::ST_SYNC;
                n_stopped  = 1'b1;
            end else begin
                n_hp = e_hp + 3'd1;
            end
        end else begin
            n_len             = len_full;
            res.packet_length = len_full;
            n_hp              = 3'd0;
            if (!count_below_max) begin
                res.status = mlpd_pkg::ST_TOOMANY;
                n_stopped  = 1'b1;
            end else if (len_full == 16'd0) begin
                res.packet_end = 1'b1;
                n_count        = e_count + mlpd_pkg::CNT_W'(1);
                if (r_last) begin
                    res.status = mlpd_pkg::ST_OK;
                    n_stopped  = 1'b1;
                end
            end else begin
                n_in_payload = 1'b1;
                n_rem        = len_full;
                if (r_last) begin
                    res.status = mlpd_pkg::ST_TRUNC;
                    n_stopped  = 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_hp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hp <= mlpd_pkg::HP_LEN_LO)
        else $error("header position out of range");

    a_payload_hp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hp == 3'd0 && r_rem != 16'd0))
        else $error("payload state inconsistent with header state");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mlpd_pkg::CNT_W'(mlpd_pkg::MAX_PACKETS))
        else $error("packet count above limit");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_hp) && $stable(r_rem) && $stable(r_stopped)))
        else $error("parse state changed without a request");
`endif

endmodule

`default_nettype wire

// ----- design/mlpd_out.sv -----
// Result register of the packet deframer.
// Holds one result until the receiver takes it; uses mlpd_pkg.
`default_nettype none

module mlpd_out (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_res_valid,
    input  wire mlpd_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire                   i_stall,
    output mlpd_pkg::t_result     o_res
);

    logic              r_valid;
    mlpd_pkg::t_result r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

`ifndef SYNTHESIS
    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status == mlpd_pkg::ST_DISCARD) |->
        (!r_res.is_payload && !r_res.packet_end && r_res.packet_length == 16'd0))
        else $error("discarded byte carries packet fields");

    a_error_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status == mlpd_pkg::ST_SYNC ||
                     r_res.status == mlpd_pkg::ST_TOOMANY ||
                     r_res.status == mlpd_pkg::ST_TRUNC)) |-> !r_res.packet_end)
        else $error("error result marked as packet end");
`endif

endmodule

`default_nettype wire

// ----- design/magic_length_packet_deframer_top.sv -----
// A request is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while not stalled; the input register and the
// result register each advance whenever the next stage can take their contents.
// Reset (synchronous, active low): both stages empty, parser waits for a first
// byte; bytes without the first mark are reported as discarded.
// Top level of the deframer; instantiates mlpd_parse and mlpd_out, uses mlpd_pkg.
`default_nettype none

module magic_length_packet_deframer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_byte_in,
    input  wire         i_first_byte,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_byte_out,
    output logic        o_is_payload,
    output logic [3:0]  o_packet_index,
    output logic [15:0] o_packet_length,
    output logic        o_packet_end,
    output logic [2:0]  o_status
);

    logic              res_valid;
    logic              out_ready;
    mlpd_pkg::t_result parse_res;
    mlpd_pkg::t_result out_res;

    mlpd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_in    (i_byte_in),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_out_ready  (out_ready),
        .o_res_valid  (res_valid),
        .o_res        (parse_res)
    );

    mlpd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (parse_res),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    assign o_byte_out      = out_res.byte_out;
    assign o_is_payload    = out_res.is_payload;
    assign o_packet_index  = out_res.packet_index;
    assign o_packet_length = out_res.packet_length;
    assign o_packet_end    = out_res.packet_end;
    assign o_status        = 3'(out_res.status);

endmodule

`default_nettype wire
